// ----- sv/cre_pkg.sv -----
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types and constants for the 6502 register execute block: the
// operation codes, flag bit positions, stack access codes and the queue entry.
// ----------------------------------------------------------------------------
package cre_pkg;

    // Operation codes, in the order of the mode field.
    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
        OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
        OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
        OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
        OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
        OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
        OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34, OP_PLP = 6'd35,
        OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
        OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43,
        OP_STY = 6'd44, OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47,
        OP_TXA = 6'd48, OP_TXS = 6'd49, OP_TYA = 6'd50
    } op_t;

    // Highest mode code that names a real operation.
    localparam logic [5:0] MODE_LAST = 6'd50;

    // Status byte bit positions.
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // Stack access codes.
    localparam logic [1:0] STACK_NONE = 2'd0;
    localparam logic [1:0] STACK_PUSH = 2'd1;
    localparam logic [1:0] STACK_PULL = 2'd2;

    // Register reset values.
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One decoded transaction as it waits in the queue.
    typedef struct packed {
        op_t        op;
        logic [7:0] operand;
        logic       to_acc;
    } cre_item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] flags;
        logic       mem_write;
        logic [7:0] write_byte;
        logic [1:0] stack_op;
        logic [7:0] stack_slot;
        logic       branch_taken;
    } cre_result_t;

endpackage

// ----- sv/cpu_6502_register_execute.sv -----
// ----------------------------------------------------------------------------
// cpu_6502_register_execute
// Execute stage of a 6502 register datapath without decimal arithmetic.
// ----------------------------------------------------------------------------
// The block takes one operation per clock cycle while the queue has room and
// returns one result per operation, in order. An accepted transaction is put
// into the queue behind the decoding front. The execute unit reads the queue
// head directly and finishes the operation with its 8-bit adder, compare
// subtractor, incrementers, logic unit and shifter; the result waits in the
// result register until it is taken. A, X, Y, the stack pointer and the
// status byte are written back at once, so back-to-back operations see each
// other's results. The queue holds QUEUE_DEPTH decoded operations and lets the
// front keep taking transactions while a result waits; the execute unit stalls
// until the result register is free or being drained. A full queue takes no
// new transaction in the cycle that it drains one. After reset A, X and Y are
// zero, the stack pointer is 0xFD and the status byte is 0x24.
// ----------------------------------------------------------------------------
module cpu_6502_register_execute #(
    parameter int QUEUE_DEPTH = cre_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [5:0] mode,
    input  logic [7:0] operand,
    input  logic       to_accumulator,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] acc_out,
    output logic [7:0] x_out,
    output logic [7:0] y_out,
    output logic [7:0] sp_out,
    output logic [7:0] flags_out,
    output logic       mem_write,
    output logic [7:0] write_byte,
    output logic [1:0] stack_op,
    output logic [7:0] stack_slot,
    output logic       branch_taken
);
    import cre_pkg::*;

    logic        push_valid;
    logic        push_ready;
    cre_item_t   push_item;
    logic        pop_valid;
    logic        pop_ready;
    cre_item_t   pop_item;
    cre_result_t result;

    // Front: accept and classify.
    cre_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .operand        (operand),
        .to_accumulator (to_accumulator),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Queue between front and back.
    cre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: execute and hold the result.
    cre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (result)
    );

    assign acc_out      = result.acc;
    assign x_out        = result.x;
    assign y_out        = result.y;
    assign sp_out       = result.sp;
    assign flags_out    = result.flags;
    assign mem_write    = result.mem_write;
    assign write_byte   = result.write_byte;
    assign stack_op     = result.stack_op;
    assign stack_slot   = result.stack_slot;
    assign branch_taken = result.branch_taken;

    // The unused status bit reads as one in every result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flags_out[FLAG_U])
        else $error("status bit 5 clear in a result");

    // A push leaves the pointer one below the slot it wrote.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_op == STACK_PUSH) |-> (sp_out == stack_slot - 8'd1))
        else $error("push pointer and slot disagree");

    // A pull leaves the pointer on the slot it read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_op == STACK_PULL) |-> (sp_out == stack_slot))
        else $error("pull pointer and slot disagree");

    // Results without a stack access or memory write carry zero side fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stack_op == STACK_NONE && !mem_write)
            |-> (stack_slot == 8'd0 && write_byte == 8'd0))
        else $error("side fields set without an access");

endmodule

// ----- sv/cre_front.sv -----
// ----------------------------------------------------------------------------
// cre_front
// Accepts input transactions and classifies the mode field into an operation
// code; unused codes become NOP. Decoded items go to the queue.
// ----------------------------------------------------------------------------
module cre_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [5:0]         mode,
    input  logic [7:0]         operand,
    input  logic               to_accumulator,
    output logic               push_valid,
    input  logic               push_ready,
    output cre_pkg::cre_item_t push_item
);
    import cre_pkg::*;

    op_t op_dec;

    // Map the mode field onto an operation; codes past the last one act as NOP.
    always_comb
    begin
        if (mode <= MODE_LAST)
        begin
            op_dec = op_t'(mode);
        end
        else
        begin
            op_dec = OP_NOP;
        end
    end

    // The front takes a transaction whenever the queue has room.
    assign in_ready           = push_ready;
    assign push_valid         = in_valid;
    assign push_item.op       = op_dec;
    assign push_item.operand  = operand;
    assign push_item.to_acc   = to_accumulator;

endmodule

// ----- sv/cre_queue.sv -----
// ----------------------------------------------------------------------------
// cre_queue
// Short register queue between the front and the back, so that either side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module cre_queue #(
    parameter int DEPTH = cre_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  cre_pkg::cre_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output cre_pkg::cre_item_t pop_item
);
    import cre_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cre_item_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates, pointers wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/cre_back.sv -----
// ----------------------------------------------------------------------------
// cre_back
// Execute part: holds A, X, Y, the stack pointer and the status byte, carries
// out one decoded operation a cycle while the output register is free or being
// drained, and keeps the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module cre_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  cre_pkg::cre_item_t   pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cre_pkg::cre_result_t out_result
);
    import cre_pkg::*;

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  x_reg, x_next;
    logic [7:0]  y_reg, y_next;
    logic [7:0]  sp_reg, sp_next;
    logic [7:0]  status_reg, status_next;
    logic        out_valid_reg, out_valid_next;
    cre_result_t result_reg, result_next;

    logic        do_exec;
    logic [7:0]  m;
    logic        cin;
    logic [7:0]  src;
    logic [7:0]  add_b;
    logic [8:0]  add_sum;
    logic [7:0]  cmp_src;
    logic [8:0]  cmp_diff;
    logic        nz_en;
    logic [7:0]  nz_val;
    logic        wr;
    logic [7:0]  wbyte;
    logic [1:0]  sop;
    logic [7:0]  slot;
    logic        br;

    // A new operation runs when the output register is free or being drained.
    assign pop_ready = !out_valid_reg || out_ready;
    assign do_exec   = pop_valid && pop_ready;

    // Shared datapath pieces: operand source, the binary adder and the compare.
    assign m        = pop_item.operand;
    assign cin      = status_reg[FLAG_C];
    assign src      = pop_item.to_acc ? acc_reg : m;
    assign add_b    = (pop_item.op == OP_SBC) ? ~m : m;
    assign add_sum  = {1'b0, acc_reg} + {1'b0, add_b} + {8'd0, cin};
    assign cmp_diff = {1'b0, cmp_src} - {1'b0, m};

    always_comb
    begin
        case (pop_item.op)
            OP_CPX:  cmp_src = x_reg;
            OP_CPY:  cmp_src = y_reg;
            default: cmp_src = acc_reg;
        endcase
    end

    // Operation decoder and register updates.
    always_comb
    begin
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        nz_en       = 1'b0;
        nz_val      = '0;
        wr          = 1'b0;
        wbyte       = '0;
        sop         = STACK_NONE;
        slot        = '0;
        br          = 1'b0;
        unique case (pop_item.op)
            OP_ADC, OP_SBC:
            begin
                acc_next            = add_sum[7:0];
                status_next[FLAG_C] = add_sum[8];
                status_next[FLAG_V] = (acc_reg[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
                nz_en               = 1'b1;
                nz_val              = add_sum[7:0];
            end
            OP_AND:
            begin
                acc_next = acc_reg & m;
                nz_en    = 1'b1;
                nz_val   = acc_reg & m;
            end
            OP_EOR:
            begin
                acc_next = acc_reg ^ m;
                nz_en    = 1'b1;
                nz_val   = acc_reg ^ m;
            end
            OP_ORA:
            begin
                acc_next = acc_reg | m;
                nz_en    = 1'b1;
                nz_val   = acc_reg | m;
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                nz_en = 1'b1;
                if (pop_item.op == OP_ASL || pop_item.op == OP_ROL)
                begin
                    nz_val              = {src[6:0], (pop_item.op == OP_ROL) & cin};
                    status_next[FLAG_C] = src[7];
                end
                else
                begin
                    nz_val              = {(pop_item.op == OP_ROR) & cin, src[7:1]};
                    status_next[FLAG_C] = src[0];
                end
                if (pop_item.to_acc)
                begin
                    acc_next = nz_val;
                end
                else
                begin
                    wr    = 1'b1;
                    wbyte = nz_val;
                end
            end
            OP_BCC: br = !status_reg[FLAG_C];
            OP_BCS: br = status_reg[FLAG_C];
            OP_BEQ: br = status_reg[FLAG_Z];
            OP_BNE: br = !status_reg[FLAG_Z];
            OP_BMI: br = status_reg[FLAG_N];
            OP_BPL: br = !status_reg[FLAG_N];
            OP_BVC: br = !status_reg[FLAG_V];
            OP_BVS: br = status_reg[FLAG_V];
            OP_BIT:
            begin
                status_next[FLAG_Z] = ((acc_reg & m) == 8'd0);
                status_next[FLAG_V] = m[6];
                status_next[FLAG_N] = m[7];
            end
            OP_CLC: status_next[FLAG_C] = 1'b0;
            OP_CLD: status_next[FLAG_D] = 1'b0;
            OP_CLI: status_next[FLAG_I] = 1'b0;
            OP_CLV: status_next[FLAG_V] = 1'b0;
            OP_SEC: status_next[FLAG_C] = 1'b1;
            OP_SED: status_next[FLAG_D] = 1'b1;
            OP_SEI: status_next[FLAG_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY:
            begin
                status_next[FLAG_C] = !cmp_diff[8];
                status_next[FLAG_Z] = (cmp_diff[7:0] == 8'd0);
                status_next[FLAG_N] = cmp_diff[7];
            end
            OP_DEC, OP_INC:
            begin
                wr     = 1'b1;
                wbyte  = (pop_item.op == OP_INC) ? m + 8'd1 : m - 8'd1;
                nz_en  = 1'b1;
                nz_val = wbyte;
            end
            OP_DEX, OP_INX:
            begin
                x_next = (pop_item.op == OP_INX) ? x_reg + 8'd1 : x_reg - 8'd1;
                nz_en  = 1'b1;
                nz_val = x_next;
            end
            OP_DEY, OP_INY:
            begin
                y_next = (pop_item.op == OP_INY) ? y_reg + 8'd1 : y_reg - 8'd1;
                nz_en  = 1'b1;
                nz_val = y_next;
            end
            OP_LDA:
            begin
                acc_next = m;
                nz_en    = 1'b1;
                nz_val   = m;
            end
            OP_LDX:
            begin
                x_next = m;
                nz_en  = 1'b1;
                nz_val = m;
            end
            OP_LDY:
            begin
                y_next = m;
                nz_en  = 1'b1;
                nz_val = m;
            end
            OP_PHA, OP_PHP:
            begin
                // Push writes at the current pointer, then moves it down.
                wr      = 1'b1;
                sop     = STACK_PUSH;
                slot    = sp_reg;
                sp_next = sp_reg - 8'd1;
                if (pop_item.op == OP_PHA)
                begin
                    wbyte = acc_reg;
                end
                else
                begin
                    wbyte         = status_reg;
                    wbyte[FLAG_B] = 1'b1;
                    wbyte[FLAG_U] = 1'b1;
                end
            end
            OP_PLA, OP_PLP:
            begin
                // Pull moves the pointer up first and reads the new slot.
                sp_next = sp_reg + 8'd1;
                sop     = STACK_PULL;
                slot    = sp_next;
                if (pop_item.op == OP_PLA)
                begin
                    acc_next = m;
                    nz_en    = 1'b1;
                    nz_val   = m;
                end
                else
                begin
                    status_next         = m;
                    status_next[FLAG_B] = 1'b0;
                    status_next[FLAG_U] = 1'b1;
                end
            end
            OP_STA:
            begin
                wr    = 1'b1;
                wbyte = acc_reg;
            end
            OP_STX:
            begin
                wr    = 1'b1;
                wbyte = x_reg;
            end
            OP_STY:
            begin
                wr    = 1'b1;
                wbyte = y_reg;
            end
            OP_TAX:
            begin
                x_next = acc_reg;
                nz_en  = 1'b1;
                nz_val = acc_reg;
            end
            OP_TAY:
            begin
                y_next = acc_reg;
                nz_en  = 1'b1;
                nz_val = acc_reg;
            end
            OP_TSX:
            begin
                x_next = sp_reg;
                nz_en  = 1'b1;
                nz_val = sp_reg;
            end
            OP_TXA:
            begin
                acc_next = x_reg;
                nz_en    = 1'b1;
                nz_val   = x_reg;
            end
            OP_TXS: sp_next = x_reg;
            OP_TYA:
            begin
                acc_next = y_reg;
                nz_en    = 1'b1;
                nz_val   = y_reg;
            end
            default:
            begin
                // NOP leaves everything as it is.
            end
        endcase
        if (nz_en)
        begin
            status_next[FLAG_Z] = (nz_val == 8'd0);
            status_next[FLAG_N] = nz_val[7];
        end
    end

    // Assemble the result transaction from the updated registers.
    always_comb
    begin
        result_next.acc          = acc_next;
        result_next.x            = x_next;
        result_next.y            = y_next;
        result_next.sp           = sp_next;
        result_next.flags        = status_next;
        result_next.mem_write    = wr;
        result_next.write_byte   = wbyte;
        result_next.stack_op     = sop;
        result_next.stack_slot   = slot;
        result_next.branch_taken = br;
    end

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Architectural registers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            sp_reg        <= SP_RESET;
            status_reg    <= STATUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_exec)
            begin
                acc_reg    <= acc_next;
                x_reg      <= x_next;
                y_reg      <= y_next;
                sp_reg     <= sp_next;
                status_reg <= status_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (do_exec)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

// ----- bench/cpu_6502_register_execute_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_6502_register_execute_tb
// Self-checking bench for the 6502 register execute stage. A behavioral copy
// of the register file and status logic predicts every result as each
// transaction is accepted. A checker compares each returned result, field by
// field, against the oldest prediction. The stimulus runs through flag and
// wrap-around corner cases, every mode code, and a long stream of random
// operations. Both handshakes idle at random, and one phase holds off the
// output long enough to back the block up.
// ----------------------------------------------------------------------------
module cpu_6502_register_execute_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cre_pkg::*;

    localparam int STALL_CYCLES = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 30;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [5:0] mode = '0;
    logic [7:0] operand = '0;
    logic       to_accumulator = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] flags_out;
    logic       mem_write;
    logic [7:0] write_byte;
    logic [1:0] stack_op;
    logic [7:0] stack_slot;
    logic       branch_taken;

    // Idling controls; written only at clock edges with nonblocking updates.
    logic no_idle = 1'b0;
    logic hold_sink = 1'b0;

    // Predicted architectural state.
    logic [7:0] a_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] sp_reg;
    logic [7:0] p_reg;

    cre_result_t pending_results[$];
    int          ops_sent = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          input_stall_cycles = 0;

    cpu_6502_register_execute DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .operand        (operand),
        .to_accumulator (to_accumulator),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .acc_out        (acc_out),
        .x_out          (x_out),
        .y_out          (y_out),
        .sp_out         (sp_out),
        .flags_out      (flags_out),
        .mem_write      (mem_write),
        .write_byte     (write_byte),
        .stack_op       (stack_op),
        .stack_slot     (stack_slot),
        .branch_taken   (branch_taken)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Overall time limit for the run.
    initial
    begin
        #2_000_000;
        $display("cpu_6502_register_execute_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction of the register datapath.
    // ------------------------------------------------------------------------

    function automatic void set_nz(logic [7:0] v);
        p_reg[FLAG_Z] = (v == 8'h00);
        p_reg[FLAG_N] = v[7];
    endfunction

    // Binary add with carry in; SBC feeds the inverted operand.
    function automatic logic [7:0] add_with_carry(logic [7:0] a, logic [7:0] b);
        logic [8:0] sum;
        logic [7:0] res;
        sum = {1'b0, a} + {1'b0, b} + {8'h00, p_reg[FLAG_C]};
        res = sum[7:0];
        p_reg[FLAG_C] = sum[8];
        p_reg[FLAG_V] = (a[7] ^ res[7]) & (b[7] ^ res[7]);
        set_nz(res);
        return res;
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] m);
        logic [7:0] diff;
        diff = r - m;
        p_reg[FLAG_C] = (r >= m);
        p_reg[FLAG_Z] = (r == m);
        p_reg[FLAG_N] = diff[7];
    endfunction

    // Applies one operation to the predicted state and returns its result.
    function automatic cre_result_t execute_6502_op(logic [5:0] code, logic [7:0] m,
                                                    logic to_acc);
        cre_result_t res;
        logic [7:0]  src;
        logic [7:0]  shifted;
        logic [7:0]  pushed_flags;
        logic        cin;
        res = '0;
        cin = p_reg[FLAG_C];
        src = to_acc ? a_reg : m;
        case (code)
            OP_ADC: a_reg = add_with_carry(a_reg, m);
            OP_SBC: a_reg = add_with_carry(a_reg, ~m);
            OP_AND: begin a_reg = a_reg & m; set_nz(a_reg); end
            OP_ORA: begin a_reg = a_reg | m; set_nz(a_reg); end
            OP_EOR: begin a_reg = a_reg ^ m; set_nz(a_reg); end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR:
            begin
                case (code)
                    OP_ASL: begin shifted = {src[6:0], 1'b0}; p_reg[FLAG_C] = src[7]; end
                    OP_LSR: begin shifted = {1'b0, src[7:1]}; p_reg[FLAG_C] = src[0]; end
                    OP_ROL: begin shifted = {src[6:0], cin};  p_reg[FLAG_C] = src[7]; end
                    default: begin shifted = {cin, src[7:1]}; p_reg[FLAG_C] = src[0]; end
                endcase
                set_nz(shifted);
                if (to_acc)
                    a_reg = shifted;
                else
                begin
                    res.mem_write  = 1'b1;
                    res.write_byte = shifted;
                end
            end
            OP_BCC: res.branch_taken = !p_reg[FLAG_C];
            OP_BCS: res.branch_taken = p_reg[FLAG_C];
            OP_BEQ: res.branch_taken = p_reg[FLAG_Z];
            OP_BNE: res.branch_taken = !p_reg[FLAG_Z];
            OP_BMI: res.branch_taken = p_reg[FLAG_N];
            OP_BPL: res.branch_taken = !p_reg[FLAG_N];
            OP_BVS: res.branch_taken = p_reg[FLAG_V];
            OP_BVC: res.branch_taken = !p_reg[FLAG_V];
            OP_BIT:
            begin
                p_reg[FLAG_Z] = ((a_reg & m) == 8'h00);
                p_reg[FLAG_V] = m[6];
                p_reg[FLAG_N] = m[7];
            end
            OP_CLC: p_reg[FLAG_C] = 1'b0;
            OP_CLD: p_reg[FLAG_D] = 1'b0;
            OP_CLI: p_reg[FLAG_I] = 1'b0;
            OP_CLV: p_reg[FLAG_V] = 1'b0;
            OP_SEC: p_reg[FLAG_C] = 1'b1;
            OP_SED: p_reg[FLAG_D] = 1'b1;
            OP_SEI: p_reg[FLAG_I] = 1'b1;
            OP_CMP: compare_reg(a_reg, m);
            OP_CPX: compare_reg(x_reg, m);
            OP_CPY: compare_reg(y_reg, m);
            OP_DEC, OP_INC:
            begin
                shifted = (code == OP_INC) ? m + 8'd1 : m - 8'd1;
                set_nz(shifted);
                res.mem_write  = 1'b1;
                res.write_byte = shifted;
            end
            OP_DEX: begin x_reg = x_reg - 8'd1; set_nz(x_reg); end
            OP_DEY: begin y_reg = y_reg - 8'd1; set_nz(y_reg); end
            OP_INX: begin x_reg = x_reg + 8'd1; set_nz(x_reg); end
            OP_INY: begin y_reg = y_reg + 8'd1; set_nz(y_reg); end
            OP_LDA: begin a_reg = m; set_nz(m); end
            OP_LDX: begin x_reg = m; set_nz(m); end
            OP_LDY: begin y_reg = m; set_nz(m); end
            // Push writes at the current slot, then the pointer moves down.
            OP_PHA, OP_PHP:
            begin
                pushed_flags = p_reg;
                pushed_flags[FLAG_B] = 1'b1;
                pushed_flags[FLAG_U] = 1'b1;
                res.mem_write  = 1'b1;
                res.stack_op   = STACK_PUSH;
                res.stack_slot = sp_reg;
                res.write_byte = (code == OP_PHA) ? a_reg : pushed_flags;
                sp_reg = sp_reg - 8'd1;
            end
            // Pull moves the pointer up first and reads the new slot.
            OP_PLA, OP_PLP:
            begin
                sp_reg = sp_reg + 8'd1;
                res.stack_op   = STACK_PULL;
                res.stack_slot = sp_reg;
                if (code == OP_PLA)
                begin
                    a_reg = m;
                    set_nz(m);
                end
                else
                begin
                    p_reg = m;
                    p_reg[FLAG_B] = 1'b0;
                    p_reg[FLAG_U] = 1'b1;
                end
            end
            OP_STA: begin res.mem_write = 1'b1; res.write_byte = a_reg; end
            OP_STX: begin res.mem_write = 1'b1; res.write_byte = x_reg; end
            OP_STY: begin res.mem_write = 1'b1; res.write_byte = y_reg; end
            OP_TAX: begin x_reg = a_reg; set_nz(x_reg); end
            OP_TAY: begin y_reg = a_reg; set_nz(y_reg); end
            OP_TSX: begin x_reg = sp_reg; set_nz(x_reg); end
            OP_TXA: begin a_reg = x_reg; set_nz(a_reg); end
            OP_TXS: sp_reg = x_reg;
            OP_TYA: begin a_reg = y_reg; set_nz(a_reg); end
            // NOP and the unused codes above the last operation.
            default: ;
        endcase
        res.acc   = a_reg;
        res.x     = x_reg;
        res.y     = y_reg;
        res.sp    = sp_reg;
        res.flags = p_reg;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one transaction, waits for it to be taken and records its result.
    task automatic send_op(logic [5:0] code, logic [7:0] m, logic to_acc);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= code;
        operand        <= m;
        to_accumulator <= to_acc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(execute_6502_op(code, m, to_acc));
        ops_sent++;
    endtask

    // Mostly real operations, a few unused codes, operands biased to edges.
    task automatic send_random_op();
        logic [5:0] code;
        logic [7:0] m;
        if ($urandom_range(99) < 8)
            code = 6'($urandom_range(63, 51));
        else
            code = 6'($urandom_range(50, 0));
        case ($urandom_range(11))
            0: m = 8'h00;
            1: m = 8'hFF;
            2: m = 8'h7F;
            3: m = 8'h80;
            4: m = 8'h01;
            default: m = 8'($urandom_range(255));
        endcase
        send_op(code, m, 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready generation and result checking.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || hold_sink)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        cre_result_t want;
        if (rst_n && in_valid && !in_ready)
            input_stall_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction arrived with no operation outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("acc_out", want.acc, acc_out);
                check_field("x_out", want.x, x_out);
                check_field("y_out", want.y, y_out);
                check_field("sp_out", want.sp, sp_out);
                check_field("flags_out", want.flags, flags_out);
                check_field("mem_write", 8'(want.mem_write), 8'(mem_write));
                check_field("write_byte", want.write_byte, write_byte);
                check_field("stack_op", 8'(want.stack_op), 8'(stack_op));
                check_field("stack_slot", want.stack_slot, stack_slot);
                check_field("branch_taken", 8'(want.branch_taken), 8'(branch_taken));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Flag boundaries, wrap-around and the stack and status special cases.
    task automatic test_corner_cases();
        send_op(OP_LDA, 8'h00, 1'b0);
        send_op(OP_LDA, 8'h7F, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);   // signed overflow into the sign bit
        send_op(OP_ADC, 8'hFF, 1'b0);   // carry out plus overflow
        send_op(OP_SBC, 8'h80, 1'b0);   // borrow with overflow
        send_op(OP_SBC, 8'hFF, 1'b0);   // borrow in
        send_op(OP_CMP, 8'hFF, 1'b0);
        send_op(OP_CPX, 8'h01, 1'b0);
        send_op(OP_CPY, 8'h00, 1'b0);
        send_op(OP_BIT, 8'hC0, 1'b0);
        send_op(OP_ROL, 8'h00, 1'b1);
        send_op(OP_ROR, 8'hFF, 1'b0);
        send_op(OP_ASL, 8'h80, 1'b0);
        send_op(OP_LSR, 8'h00, 1'b1);
        send_op(OP_INC, 8'hFF, 1'b1);   // accumulator flag is ignored here
        send_op(OP_DEC, 8'h00, 1'b0);
        send_op(OP_DEX, 8'h00, 1'b0);
        send_op(OP_PHP, 8'h00, 1'b0);
        send_op(OP_PLP, 8'hFF, 1'b0);   // break bit must come back clear
        send_op(OP_LDX, 8'h00, 1'b0);
        send_op(OP_TXS, 8'h00, 1'b0);
        send_op(OP_PHA, 8'h00, 1'b0);   // push at slot zero wraps the pointer
        send_op(OP_PLA, 8'h80, 1'b0);
        send_op(6'd63, 8'hFF, 1'b1);    // unused code behaves as NOP
        send_op(OP_SED, 8'h00, 1'b0);
        send_op(OP_ADC, 8'h09, 1'b0);   // decimal flag does not change the add
    endtask

    // Every mode code once, both halves of the accumulator flag.
    task automatic test_every_mode();
        for (int code = 0; code < 64; code++)
            send_op(6'(code), 8'($urandom_range(255)), 1'(code));
    endtask

    task automatic test_random_ops(int count);
        repeat (count)
            send_random_op();
    endtask

    // Back-to-back traffic on both sides.
    task automatic test_steady_stream(int count);
        no_idle <= 1'b1;
        test_random_ops(count);
        no_idle <= 1'b0;
    endtask

    // The output is held off while input keeps coming, so the block fills up.
    task automatic test_output_stall(int count);
        fork
            begin
                hold_sink <= 1'b1;
                repeat (STALL_CYCLES) @(posedge clk);
                hold_sink <= 1'b0;
            end
        join_none
        test_random_ops(count);
    endtask

    // ------------------------------------------------------------------------
    // Sequence.
    // ------------------------------------------------------------------------

    initial
    begin
        a_reg  = 8'h00;
        x_reg  = 8'h00;
        y_reg  = 8'h00;
        sp_reg = SP_RESET;
        p_reg  = STATUS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_every_mode();
        test_random_ops(700);
        test_steady_stream(300);
        test_output_stall(40);
        test_random_ops(810);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operations over all 64 mode codes and checked %0d results.",
                 ops_sent, results_checked);
        $display("Input was held back for %0d cycles, including a %0d-cycle output stall.",
                 input_stall_cycles, STALL_CYCLES);
        if (mismatch_count == 0)
            $display("cpu_6502_register_execute_tb: done, clean");
        else
            $display("cpu_6502_register_execute_tb: done, errors");
        $finish;
    end

endmodule
